/* src/cbip_pkg.sv */
`default_nettype none
package cbip_pkg;

  localparam int CHAR_CODES     = 256;
  localparam int CODE_BITS      = 8;
  localparam int DIGIT_BITS     = 9;
  localparam int VALUE_BITS     = 32;
  localparam int OUT_BITS       = 32;
  localparam int QDEPTH         = 2;
  localparam int OUT_DEPTH      = 4;
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 40;

  localparam logic [CODE_BITS-1:0] CH_NUL   = 8'd0;
  localparam logic [CODE_BITS-1:0] CH_TAB   = 8'd9;
  localparam logic [CODE_BITS-1:0] CH_CR    = 8'd13;
  localparam logic [CODE_BITS-1:0] CH_SPACE = 8'd32;
  localparam logic [CODE_BITS-1:0] CH_PLUS  = 8'd43;
  localparam logic [CODE_BITS-1:0] CH_MINUS = 8'd45;

  localparam logic ACT_ALPHA = 1'b0;
  localparam logic ACT_TEXT  = 1'b1;

  // classified input word
  typedef struct packed {
    logic                 text;
    logic [CODE_BITS-1:0] code;
    logic                 last;
    logic                 ws;
    logic                 minus;
    logic                 plus;
    logic                 forbid;
  } item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic                base_ok;
  } result_t;

endpackage
`default_nettype wire

/* src/custom_base_integer_parser.sv */
// Channel  Ports                          Word contents
// -------  -----------------------------  ----------------------------------------
// in       in_tvalid/in_tready/in_tdata   tdata[7:0] char_code, tuser action,
//                                         tlast last
// out      out_tvalid/out_tready/out_tdata tdata[31:0] value, tdata[32] base_ok
//
// One word per cycle sustained while neither queue stalls: each word takes one table read
// (registered RAM port), and each digit one multiply-add of the accumulator by the radix.
// From input to result a word passes the queue, the table read and the result queue.
// rst_n (synchronous) empties the digit table at once through per-code valid bits.
// Input and output stall independently: a two-entry queue sits after the input
// and a four-entry queue holds results; text ends wait only for result space.
`default_nettype none
module custom_base_integer_parser #(
  parameter int VALUE_BITS = cbip_pkg::VALUE_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [cbip_pkg::IN_TDATA_BITS-1:0]   in_tdata,   // [7:0] char_code
  input  wire logic                                 in_tuser,   // [0] action
  input  wire logic                                 in_tlast,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic      [cbip_pkg::OUT_TDATA_BITS-1:0]  out_tdata   // [31:0] value, [32] base_ok
);

  logic            head_valid;
  cbip_pkg::item_t head;
  logic            pop;

  cbip_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  cbip_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

/* src/cbip_ram.sv */
`default_nettype none
module cbip_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/cbip_front.sv */
`default_nettype none
module cbip_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [cbip_pkg::IN_TDATA_BITS-1:0]    in_tdata,
  input  wire logic                                  in_tuser,
  input  wire logic                                  in_tlast,
  input  wire logic                                  pop,
  output logic                                       head_valid,
  output cbip_pkg::item_t                            head
);

  localparam int QPTR = $clog2(cbip_pkg::QDEPTH);
  localparam int QCNT = $clog2(cbip_pkg::QDEPTH + 1);

  cbip_pkg::item_t         mem_r [cbip_pkg::QDEPTH];
  cbip_pkg::item_t         cls;
  logic [QPTR-1:0]         wr_ptr_r, rd_ptr_r;
  logic [QCNT-1:0]         cnt_r, cnt_nxt;
  logic                    push;
  logic [cbip_pkg::CODE_BITS-1:0] code;

  assign code = in_tdata[cbip_pkg::CODE_BITS-1:0];

  always_comb begin
    cls.text  = (in_tuser == cbip_pkg::ACT_TEXT);
    cls.code  = code;
    cls.last  = in_tlast;
    cls.ws    = ((code >= cbip_pkg::CH_TAB) && (code <= cbip_pkg::CH_CR)) ||
                (code == cbip_pkg::CH_SPACE);
    cls.minus = (code == cbip_pkg::CH_MINUS);
    cls.plus  = (code == cbip_pkg::CH_PLUS);
    cls.forbid = cls.ws || cls.minus || cls.plus || (code == cbip_pkg::CH_NUL);
  end

  assign in_tready  = (cnt_r != QCNT'(cbip_pkg::QDEPTH));
  assign push       = in_tvalid && in_tready;
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

/* src/cbip_back.sv */
`default_nettype none
module cbip_back #(
  parameter int VALUE_BITS = cbip_pkg::VALUE_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 head_valid,
  input  wire cbip_pkg::item_t                      head,
  output logic                                      pop,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic      [cbip_pkg::OUT_TDATA_BITS-1:0]  out_tdata
);

  typedef enum logic [1:0] {PH_SPACE, PH_SIGN, PH_DIGIT, PH_DONE} phase_t;

  localparam int DB   = cbip_pkg::DIGIT_BITS;
  localparam int OB   = cbip_pkg::OUT_BITS;
  localparam int OPTR = $clog2(cbip_pkg::OUT_DEPTH);
  localparam int OCNT = $clog2(cbip_pkg::OUT_DEPTH + 1);
  localparam int PAD  = cbip_pkg::OUT_TDATA_BITS - OB - 1;

  // lookup stage
  logic                       s1_valid_r;
  cbip_pkg::item_t            s1_item_r;
  logic                       byp_hit_r;
  logic [DB-1:0]              byp_data_r;
  logic [DB-1:0]              ram_rdata;
  logic [DB-1:0]              digit_val;
  logic                       is_digit;

  // alphabet and parse state
  logic [cbip_pkg::CHAR_CODES-1:0] valid_r, valid_nxt;
  logic [DB-1:0]              radix_r, radix_nxt;
  logic                       bad_r, bad_nxt;
  logic                       open_r, open_nxt;
  phase_t                     phase_r, phase_nxt;
  logic                       neg_r, neg_nxt;
  logic [VALUE_BITS-1:0]      acc_r, acc_nxt;

  logic                       wr_en;
  logic [DB-1:0]              wr_data;
  logic [VALUE_BITS+DB-1:0]   prod;
  logic [VALUE_BITS-1:0]      mac;
  logic                       res_push;
  cbip_pkg::result_t          res_data;

  // result queue
  cbip_pkg::result_t          omem_r [cbip_pkg::OUT_DEPTH];
  logic [OPTR-1:0]            owr_r, ord_r;
  logic [OCNT-1:0]            ocnt_r, ocnt_nxt;
  logic [OCNT-1:0]            owed_r, owed_nxt;
  logic                       out_hs;
  logic                       pop_res;
  cbip_pkg::result_t          ohead;

  // a result word may leave the queue only when space for it is reserved
  assign pop_res = head.text && head.last;
  assign pop     = head_valid && (!pop_res || (owed_r < OCNT'(cbip_pkg::OUT_DEPTH)));

  cbip_ram #(
    .WIDTH (DB),
    .DEPTH (cbip_pkg::CHAR_CODES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_item_r.code),
    .wdata (wr_data),
    .re    (pop),
    .raddr (head.code),
    .rdata (ram_rdata)
  );

  assign digit_val = byp_hit_r ? byp_data_r : ram_rdata;
  assign is_digit  = valid_r[s1_item_r.code];
  assign prod      = {{DB{1'b0}}, acc_r} * {{VALUE_BITS{1'b0}}, radix_r};
  assign mac       = prod[VALUE_BITS-1:0] + VALUE_BITS'(digit_val);

  always_comb begin
    logic                  fresh;
    logic                  bad_eff;
    logic [DB-1:0]         radix_eff;
    logic                  taken;
    phase_t                ph;
    logic                  neg_v;
    logic [VALUE_BITS-1:0] acc_v;
    logic [VALUE_BITS-1:0] mag;
    logic                  ok;

    fresh     = 1'b0;
    bad_eff   = bad_r;
    radix_eff = radix_r;
    taken     = 1'b0;
    ph        = phase_r;
    neg_v     = neg_r;
    acc_v     = acc_r;
    mag       = '0;
    ok        = 1'b0;

    valid_nxt = valid_r;
    radix_nxt = radix_r;
    bad_nxt   = bad_r;
    open_nxt  = open_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    wr_en     = 1'b0;
    wr_data   = radix_r;
    res_push  = 1'b0;
    res_data  = '0;

    if (s1_valid_r) begin
      if (!s1_item_r.text) begin
        // first word of a new alphabet wipes the table
        fresh = !open_r;
        if (fresh) begin
          valid_nxt = '0;
          radix_eff = '0;
          bad_eff   = 1'b0;
        end
        radix_nxt = radix_eff;
        bad_nxt   = bad_eff;
        wr_data   = radix_eff;
        if (!bad_eff) begin
          if (s1_item_r.forbid || (!fresh && is_digit)) begin
            bad_nxt = 1'b1;
          end else begin
            wr_en                     = 1'b1;
            valid_nxt[s1_item_r.code] = 1'b1;
            radix_nxt                 = radix_eff + 1'b1;
          end
        end
        open_nxt = !s1_item_r.last;
      end else begin
        if (ph == PH_SPACE) begin
          if (s1_item_r.ws) begin
            taken = 1'b1;
          end else begin
            ph = PH_SIGN;
          end
        end
        if (!taken && (ph == PH_SIGN)) begin
          if (s1_item_r.minus) begin
            neg_v = !neg_v;
            taken = 1'b1;
          end else if (s1_item_r.plus) begin
            taken = 1'b1;
          end else begin
            ph = PH_DIGIT;
          end
        end
        if (!taken && (ph == PH_DIGIT)) begin
          if (is_digit) begin
            acc_v = mac;
          end else begin
            ph = PH_DONE;
          end
        end

        if (s1_item_r.last) begin
          ok  = !bad_r && (radix_r >= DB'(2));
          mag = neg_v ? (~acc_v + 1'b1) : acc_v;
          res_push         = 1'b1;
          res_data.base_ok = ok;
          res_data.value   = ok ? OB'($signed(mag)) : '0;
          phase_nxt        = PH_SPACE;
          neg_nxt          = 1'b0;
          acc_nxt          = '0;
        end else begin
          phase_nxt = ph;
          neg_nxt   = neg_v;
          acc_nxt   = acc_v;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_hit_r  <= 1'b0;
      valid_r    <= '0;
      radix_r    <= '0;
      bad_r      <= 1'b0;
      open_r     <= 1'b0;
      phase_r    <= PH_SPACE;
      neg_r      <= 1'b0;
      acc_r      <= '0;
    end else begin
      s1_valid_r <= pop;
      // table write lands on the same edge as the next read: forward it
      byp_hit_r  <= wr_en && (head.code == s1_item_r.code);
      valid_r    <= valid_nxt;
      radix_r    <= radix_nxt;
      bad_r      <= bad_nxt;
      open_r     <= open_nxt;
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      acc_r      <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item_r  <= head;
      byp_data_r <= wr_data;
    end
  end

  // result queue
  assign out_hs     = out_tvalid && out_tready;
  assign out_tvalid = (ocnt_r != '0);
  assign ohead      = omem_r[ord_r];
  assign out_tdata  = {{PAD{1'b0}}, ohead.base_ok, ohead.value};

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (res_push && !out_hs) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (out_hs && !res_push) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
    owed_nxt = owed_r;
    if ((pop && pop_res) && !out_hs) begin
      owed_nxt = owed_r + 1'b1;
    end else if (out_hs && !(pop && pop_res)) begin
      owed_nxt = owed_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
      owed_r <= '0;
    end else begin
      if (res_push) begin
        owr_r <= owr_r + 1'b1;
      end
      if (out_hs) begin
        ord_r <= ord_r + 1'b1;
      end
      ocnt_r <= ocnt_nxt;
      owed_r <= owed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      omem_r[owr_r] <= res_data;
    end
  end

endmodule
`default_nettype wire
